// ===== design/rme_pkg.sv =====
// package: widths, constants and arctangent table for the euler angle pipeline
`timescale 1ns / 1ps
package rme_pkg;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned CW = 34;
  localparam int unsigned ZW = 28;
  localparam logic signed [ZW-1:0] HalfPiI = 28'sd26353589;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [16:0] OneQ14 = 17'sd16384;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    begin
      unique case (i)
        5'd0: v = 28'sd13176795;
        5'd1: v = 28'sd7778716;
        5'd2: v = 28'sd4110060;
        5'd3: v = 28'sd2086331;
        5'd4: v = 28'sd1047214;
        5'd5: v = 28'sd524117;
        5'd6: v = 28'sd262123;
        5'd7: v = 28'sd131069;
        default: v = ZW'(28'sd1 <<< (5'd24 - i));
      endcase
      return v;
    end
  endfunction

endpackage

// ===== design/rme_atan2.sv =====
// pipelined vectoring cordic computing atan2(y, x) in q3.13
`timescale 1ns / 1ps
module rme_atan2
  import rme_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [17:0] y_i,
  input  logic signed [17:0] x_i,
  output logic signed [15:0] ang_o
);

  cordic_t st_q [CordicStages+1];
  cordic_t st_d;

  // quadrant fold and scale into stage 0
  always_comb begin
    st_d.zero = (x_i == '0) && (y_i == '0);
    st_d.z    = '0;
    st_d.x    = CW'(x_i) <<< 12;
    st_d.y    = CW'(y_i) <<< 12;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        st_d.x = CW'(y_i) <<< 12;
        st_d.y = (-CW'(x_i)) <<< 12;
        st_d.z = HalfPiI;
      end else begin
        st_d.x = (-CW'(y_i)) <<< 12;
        st_d.y = CW'(x_i) <<< 12;
        st_d.z = -HalfPiI;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st_d;
  end

  // one micro-rotation per stage
  for (genvar g = 0; g < CordicStages; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      st_q[g+1].zero <= st_q[g].zero;
      if (st_q[g].y >= 0) begin
        st_q[g+1].x <= st_q[g].x + (st_q[g].y >>> g);
        st_q[g+1].y <= st_q[g].y - (st_q[g].x >>> g);
        st_q[g+1].z <= st_q[g].z + atan_tab(5'(g));
      end else begin
        st_q[g+1].x <= st_q[g].x - (st_q[g].y >>> g);
        st_q[g+1].y <= st_q[g].y + (st_q[g].x >>> g);
        st_q[g+1].z <= st_q[g].z - atan_tab(5'(g));
      end
    end
  end

  logic signed [ZW-1:0] zr;
  assign zr    = st_q[CordicStages].z + ZW'(1024);
  assign ang_o = st_q[CordicStages].zero ? '0 : 16'(zr >>> 11);

endmodule

// ===== design/rme_sqrt.sv =====
// pipelined rounded integer square root of a 29 bit value, one result bit per stage
`timescale 1ns / 1ps
module rme_sqrt
  import rme_pkg::*;
(
  input  logic        clk_i,
  input  logic [28:0] v_i,
  output logic [15:0] r_o
);

  localparam int unsigned Steps = 15;

  logic [29:0] rem_q [Steps+1];
  logic [15:0] root_q [Steps+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= 30'(v_i);
    root_q[0] <= '0;
  end

  // restoring digit recurrence, bit weights from 2^28 down
  for (genvar g = 0; g < Steps; g++) begin : g_step
    localparam logic [29:0] Bit = 30'd1 << (2 * (Steps - 1 - g));
    logic [29:0] trial;
    // (2 * root + 1) scaled to the weight of the bit under test
    assign trial = (30'(root_q[g]) << (2 * (Steps - 1 - g) + 2)) + Bit;
    always_ff @(posedge clk_i) begin
      if (rem_q[g] >= trial) begin
        rem_q[g+1]  <= rem_q[g] - trial;
        root_q[g+1] <= {root_q[g][14:0], 1'b1};
      end else begin
        rem_q[g+1]  <= rem_q[g];
        root_q[g+1] <= {root_q[g][14:0], 1'b0};
      end
    end
  end

  // round to nearest
  assign r_o = (rem_q[Steps] > 30'(root_q[Steps])) ? root_q[Steps] + 16'd1 : root_q[Steps];

endmodule

// ===== design/rotation_matrix_to_euler.sv =====
// top level: rotation matrix to xyz euler angles, fully pipelined
`timescale 1ns / 1ps
//  channel | ports                              | handshake
//  request | m00_i..m22_i                       | start_i, taken when busy_o low
//  result  | roll_o pitch_o yaw_o gimbal_lock_o | done_o, one cycle, no stall
//  config  | lock_margin_i                      | lock_margin_we_i
// one matrix enters per cycle; busy_o is always low.
// done_o rises when the result leaves the output register; the path is 16 sqrt
// registers (the first loads at the accepting edge), CordicStages + 1 cordic
// registers and the output register.
// reset clears the valid chain and lock_margin; payload registers are not reset.
module rotation_matrix_to_euler
  import rme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] m00_i,
  input  logic signed [15:0] m01_i,
  input  logic signed [15:0] m02_i,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m21_i,
  input  logic signed [15:0] m22_i,
  input  logic               lock_margin_we_i,
  input  logic [10:0]        lock_margin_i,
  output logic               done_o,
  output logic signed [15:0] roll_o,
  output logic signed [15:0] pitch_o,
  output logic signed [15:0] yaw_o,
  output logic               gimbal_lock_o
);

  localparam int unsigned SqLat = 16;
  localparam int unsigned Lat = SqLat + CordicStages + 1;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m11, m12, m21, m22;
    logic               lock;
  } item_t;

  logic [10:0] margin_q;
  logic signed [16:0] mg_s;
  logic        start;
  item_t       in_q [SqLat];
  logic [Lat:0] vld_q;

  assign busy_o = 1'b0;
  assign start  = start_i && !busy_o;
  assign mg_s   = {6'd0, margin_q};

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
    end else if (lock_margin_we_i) begin
      margin_q <= lock_margin_i;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-1:0], start};
    end
  end

  // lock test and delay line alongside the square root
  item_t in_d;
  always_comb begin
    in_d = '{m00: m00_i, m01: m01_i, m02: m02_i, m11: m11_i, m12: m12_i,
             m21: m21_i, m22: m22_i, lock: 1'b0};
    in_d.lock = !((17'(m02_i) < OneQ14 - mg_s) &&
                  (17'(m02_i) > mg_s - OneQ14));
  end

  always_ff @(posedge clk_i) begin
    in_q[0] <= in_d;
    for (int k = 0; k < SqLat - 1; k++) in_q[k+1] <= in_q[k];
  end

  // cosine term for asin
  logic signed [31:0] sq;
  logic [28:0]        rem;
  logic [15:0]        cosv;
  assign sq  = 32'sd268435456 - 32'(in_d.m02) * 32'(in_d.m02);
  assign rem = in_d.lock ? '0 : 29'(sq);

  rme_sqrt u_sqrt (.clk_i, .v_i(rem), .r_o(cosv));

  // operands aligned with the sqrt result at the end of the delay line
  item_t      a;
  logic signed [17:0] ry, rx;
  assign a  = in_q[SqLat-1];
  assign ry = a.lock ? -18'(a.m21) : 18'(a.m12);
  assign rx = a.lock ? 18'(a.m11) : 18'(a.m22);

  logic signed [15:0] roll_a, pitch_a, yaw_a;
  rme_atan2 u_roll  (.clk_i, .y_i(ry), .x_i(rx), .ang_o(roll_a));
  rme_atan2 u_pitch (.clk_i, .y_i(18'(a.m02)), .x_i(18'({1'b0, cosv})), .ang_o(pitch_a));
  rme_atan2 u_yaw   (.clk_i, .y_i(18'(a.m01)), .x_i(18'(a.m00)), .ang_o(yaw_a));

  // lock flags and m02 sign ride along the cordic
  logic [CordicStages:0] lk_q, pos_q, neg_q;
  always_ff @(posedge clk_i) begin
    lk_q  <= {lk_q[CordicStages-1:0], a.lock};
    pos_q <= {pos_q[CordicStages-1:0], a.m02 > 0};
    neg_q <= {neg_q[CordicStages-1:0], a.m02 < 0};
  end

  // output register
  always_ff @(posedge clk_i) begin
    roll_o        <= roll_a;
    gimbal_lock_o <= lk_q[CordicStages];
    if (lk_q[CordicStages]) begin
      yaw_o   <= '0;
      pitch_o <= pos_q[CordicStages] ? -HalfPiQ13 :
                 (neg_q[CordicStages] ? HalfPiQ13 : '0);
    end else begin
      yaw_o   <= yaw_a;
      pitch_o <= -pitch_a;
    end
  end

  assign done_o = vld_q[Lat];

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[Lat-1]))
    else $error("done without item");
  a_lock_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && gimbal_lock_o) |-> (yaw_o == '0))
    else $error("yaw not zero in lock");

endmodule
